// File: hdl/gf2_shear_weight_scorer_defines.svh
// Assertion macros used by the RTL of the shear weight scorer.
`ifndef GF2_SHEAR_WEIGHT_SCORER_DEFINES_SVH
`define GF2_SHEAR_WEIGHT_SCORER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define GSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/gsws_pkg.sv
`default_nettype none

package gsws_pkg;

    localparam int MatN        = 32;
    localparam int IdxW        = 5;
    localparam int RowW        = 32;
    localparam int WgtW        = 6;
    localparam int ShiftA      = 13;
    localparam int ShiftB      = 17;
    localparam int ShiftC      = 5;
    localparam int WeightLimit = 4;
    localparam int ScoreRows   = 3 * MatN;
    localparam int CntW        = 7;
    localparam int InTdataW    = 16;
    localparam int OutTdataW   = 48;

    localparam logic FUNC_GUARDED   = 1'b0;
    localparam logic FUNC_UNGUARDED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHEAR,
        ST_SCORE,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    function automatic logic [RowW-1:0] step_map(input logic [RowW-1:0] v);
        logic [RowW-1:0] x;
        x = v;
        x = x ^ (x >> ShiftA);
        x = x ^ (x << ShiftB);
        x = x ^ (x >> ShiftC);
        return x;
    endfunction

    // Row t of the xorshift transition matrix: bit s is bit t of the map of 1 << s.
    function automatic logic [RowW-1:0] xs_row(input int t);
        logic [RowW-1:0] row;
        logic [RowW-1:0] img;
        row = '0;
        for (int s = 0; s < MatN; s++) begin
            img    = step_map(RowW'(1) << s);
            row[s] = img[t];
        end
        return row;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gsws_popcnt.sv
`default_nettype none

module gsws_popcnt (
    input  logic [gsws_pkg::RowW-1:0] i_word,
    output logic [gsws_pkg::WgtW-1:0] o_count
);
    import gsws_pkg::*;

    localparam int Bytes = RowW / 8;

    logic [3:0] w_byte_cnt [Bytes];

    always_comb begin
        for (int b = 0; b < Bytes; b++) begin
            w_byte_cnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                w_byte_cnt[b] = w_byte_cnt[b] + 4'(i_word[8*b+k]);
            end
        end
    end

    assign o_count = (WgtW'(w_byte_cnt[0]) + WgtW'(w_byte_cnt[1]))
                   + (WgtW'(w_byte_cnt[2]) + WgtW'(w_byte_cnt[3]));

endmodule

`default_nettype wire

// File: hdl/gf2_shear_weight_scorer.sv
// The block holds three 32x32 GF(2) matrices in registers and applies one
// elementary shear per input word, then returns one word of row-weight
// scores. A word passes from acceptance to a loaded result through the shear
// state, which updates all rows at once, the score state, in which a single
// shared popcount unit walks the basis, conjugate and right rows one per
// cycle, and the drain and finish states, which drain the accumulator and load
// the output register. The input is ready only while the block is idle, so the
// next word is taken in the cycle after the load at the earliest; a finished
// result waits in the output register while the next word is taken. The
// matrices take their reset values at once, with no clearing pass.
`default_nettype none
`include "gf2_shear_weight_scorer_defines.svh"

module gf2_shear_weight_scorer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: dst_index[4:0], src_index[9:5], zero padding.
    input  logic [gsws_pkg::InTdataW-1:0]    s_axis_tdata,
    // Fields from bit 0: func.
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: excess[15:0], heavy_rows[22:16], max_weight[28:23],
    // total_weight[40:29], init_pairs[46:41], zero padding.
    output logic [gsws_pkg::OutTdataW-1:0]   m_axis_tdata,
    // Fields from bit 0: applied.
    output logic                             m_axis_tuser
);
    import gsws_pkg::*;

    t_state             r_state, n_state;
    logic [RowW-1:0]    r_basis [MatN];
    logic [RowW-1:0]    r_conj  [MatN];
    logic [RowW-1:0]    r_right [MatN];
    logic               r_func;
    logic [IdxW-1:0]    r_dst, r_src;
    logic               r_applied;
    logic [CntW-1:0]    r_idx;
    logic [WgtW-1:0]    r_w;
    logic               r_w_basis;
    logic               r_wv;
    logic [15:0]        r_excess;
    logic [6:0]         r_heavy;
    logic [WgtW-1:0]    r_max;
    logic [11:0]        r_total;
    logic [WgtW-1:0]    r_pairs;
    logic               r_out_valid;
    logic [OutTdataW-1:0] r_out_data;
    logic               r_out_applied;

    logic               w_accept;
    logic               w_load;
    logic [RowW-1:0]    w_next, w_x1, w_x2, w_sbit;
    logic               w_go;
    logic [RowW-1:0]    w_conj_f  [MatN];
    logic [RowW-1:0]    w_right_f [MatN];
    logic [RowW-1:0]    w_row;
    logic [WgtW-1:0]    w_cnt;
    logic [4:0]         w_e;
    logic [9:0]         w_sq;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = (r_state == ST_FINISH) && (!r_out_valid || m_axis_tready);

    assign w_next = r_basis[r_dst] ^ r_basis[r_src];
    assign w_x1   = w_next & (w_next - RowW'(1));
    assign w_x2   = w_x1 & (w_x1 - RowW'(1));
    assign w_go   = (r_func == FUNC_UNGUARDED)
                 || ((r_src != r_dst) && (w_next != '0) && (w_x2 == '0));
    assign w_sbit = RowW'(1) << r_src;

    always_comb begin
        for (int r = 0; r < MatN; r++) begin
            w_conj_f[r]  = r_conj[r]  ^ (r_conj[r][r_dst]  ? w_sbit : '0);
            w_right_f[r] = r_right[r] ^ (r_right[r][r_dst] ? w_sbit : '0);
        end
    end

    always_comb begin
        unique case (r_idx[CntW-1:IdxW])
            2'd0:    w_row = r_basis[r_idx[IdxW-1:0]];
            2'd1:    w_row = r_conj[r_idx[IdxW-1:0]];
            2'd2:    w_row = r_right[r_idx[IdxW-1:0]];
            default: w_row = '0;
        endcase
    end

    gsws_popcnt u_popcnt (
        .i_word  (w_row),
        .o_count (w_cnt)
    );

    assign w_e  = 5'(r_w - WgtW'(WeightLimit));
    assign w_sq = 10'(w_e) * 10'(w_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_SHEAR;
                end
            end
            ST_SHEAR: begin
                n_state = ST_SCORE;
            end
            ST_SCORE: begin
                if (r_idx == CntW'(ScoreRows - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MatN; r++) begin
                r_basis[r] <= RowW'(1) << r;
                r_conj[r]  <= xs_row(r);
                r_right[r] <= xs_row(r);
            end
            r_idx       <= '0;
            r_wv        <= 1'b0;
            r_excess    <= '0;
            r_heavy     <= '0;
            r_max       <= '0;
            r_total     <= '0;
            r_pairs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_SHEAR) begin
                if (w_go) begin
                    r_basis[r_dst] <= w_next;
                    for (int r = 0; r < MatN; r++) begin
                        if (IdxW'(r) == r_dst) begin
                            r_conj[r] <= w_conj_f[r_dst] ^ w_conj_f[r_src];
                        end else begin
                            r_conj[r] <= w_conj_f[r];
                        end
                        r_right[r] <= w_right_f[r];
                    end
                end
                r_idx    <= '0;
                r_excess <= '0;
                r_heavy  <= '0;
                r_max    <= '0;
                r_total  <= '0;
                r_pairs  <= '0;
            end
            if (r_state == ST_SCORE) begin
                r_idx <= r_idx + CntW'(1);
                r_wv  <= 1'b1;
            end else begin
                r_wv  <= 1'b0;
            end
            if (r_wv) begin
                if (r_w_basis) begin
                    if (r_w == WgtW'(2)) begin
                        r_pairs <= r_pairs + WgtW'(1);
                    end
                end else begin
                    r_total <= r_total + 12'(r_w);
                    if (r_w > r_max) begin
                        r_max <= r_w;
                    end
                    if (r_w > WgtW'(WeightLimit)) begin
                        r_heavy  <= r_heavy + 7'(1);
                        r_excess <= r_excess + 16'(w_sq);
                    end
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= s_axis_tuser;
            r_dst  <= s_axis_tdata[IdxW-1:0];
            r_src  <= s_axis_tdata[2*IdxW-1:IdxW];
        end
        if (r_state == ST_SHEAR) begin
            r_applied <= w_go;
        end
        if (r_state == ST_SCORE) begin
            r_w       <= w_cnt;
            r_w_basis <= (r_idx < CntW'(MatN));
        end
        if (w_load) begin
            r_out_data    <= {1'b0, r_pairs, r_total, r_max, r_heavy, r_excess};
            r_out_applied <= r_applied;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_applied;

    `GSWS_ASSERT_NEXT(a_accept_starts_shear, i_clk, i_rst_n, w_accept, r_state == ST_SHEAR)
    `GSWS_ASSERT_NOW(a_weight_only_in_walk, i_clk, i_rst_n, r_wv, (r_state == ST_SCORE) || (r_state == ST_DRAIN))
    `GSWS_ASSERT_NEXT(a_refused_keeps_basis, i_clk, i_rst_n, (r_state == ST_SHEAR) && !w_go, $stable(r_basis[r_dst]) && !r_applied)
    `GSWS_ASSERT_NOW(a_scores_consistent, i_clk, i_rst_n, r_state == ST_FINISH, (r_heavy <= 7'd64) && (12'(r_max) <= r_total))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import gsws_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 200;
    localparam int ReportLimit   = 10;

    typedef struct packed {
        logic        applied;
        logic [15:0] excess;
        logic [6:0]  heavy_rows;
        logic [5:0]  max_weight;
        logic [11:0] total_weight;
        logic [5:0]  init_pairs;
    } t_score;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0: dst_index[4:0], src_index[9:5], zero padding.
    logic [InTdataW-1:0]  s_axis_tdata  = '0;
    // Fields from bit 0: func.
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0: excess[15:0], heavy_rows[22:16], max_weight[28:23],
    // total_weight[40:29], init_pairs[46:41], zero padding.
    logic [OutTdataW-1:0] m_axis_tdata;
    // Fields from bit 0: applied.
    logic                 m_axis_tuser;

    logic [RowW-1:0] basis_mat [MatN];
    logic [RowW-1:0] conj_mat  [MatN];
    logic [RowW-1:0] right_mat [MatN];

    t_score     pending_scores [$];
    logic [9:0] undo_pairs     [$];
    int         error_count  = 0;
    int         stall_cycles = 0;
    int         ready_hold   = 0;
    bit         idle_on      = 1'b1;

    gf2_shear_weight_scorer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [RowW-1:0] scramble_word(input logic [RowW-1:0] v);
        logic [RowW-1:0] x;
        x = v;
        x = x ^ (x >> ShiftA);
        x = x ^ (x << ShiftB);
        x = x ^ (x >> ShiftC);
        return x;
    endfunction

    task automatic load_reset_state();
        logic [RowW-1:0] img;
        for (int t = 0; t < MatN; t++) begin
            conj_mat[t] = '0;
        end
        for (int s = 0; s < MatN; s++) begin
            img = scramble_word(RowW'(1) << s);
            basis_mat[s] = RowW'(1) << s;
            for (int t = 0; t < MatN; t++) begin
                conj_mat[t][s] = img[t];
            end
        end
        for (int t = 0; t < MatN; t++) begin
            right_mat[t] = conj_mat[t];
        end
    endtask

    function automatic t_score shear_and_score(input logic func, input logic [4:0] dst,
                                               input logic [4:0] src);
        t_score          sc;
        logic [RowW-1:0] next_row;
        logic [RowW-1:0] dmask;
        logic [RowW-1:0] smask;
        logic            go;
        int              w;
        int              excess;
        int              heavy;
        int              maxw;
        int              total;
        int              pairs;
        next_row = basis_mat[dst] ^ basis_mat[src];
        dmask    = RowW'(1) << dst;
        smask    = RowW'(1) << src;
        go       = 1'b1;
        if (func == FUNC_GUARDED) begin
            w = $countones(next_row);
            if (src == dst || w == 0 || w > 2) begin
                go = 1'b0;
            end
        end
        if (go) begin
            basis_mat[dst] = next_row;
            for (int r = 0; r < MatN; r++) begin
                if ((conj_mat[r] & dmask) != '0) begin
                    conj_mat[r] = conj_mat[r] ^ smask;
                end
            end
            conj_mat[dst] = conj_mat[dst] ^ conj_mat[src];
            for (int r = 0; r < MatN; r++) begin
                if ((right_mat[r] & dmask) != '0) begin
                    right_mat[r] = right_mat[r] ^ smask;
                end
            end
        end
        excess = 0;
        heavy  = 0;
        maxw   = 0;
        total  = 0;
        pairs  = 0;
        for (int r = 0; r < MatN; r++) begin
            if ($countones(basis_mat[r]) == 2) begin
                pairs++;
            end
            for (int k = 0; k < 2; k++) begin
                w = $countones(k == 0 ? conj_mat[r] : right_mat[r]);
                if (w > maxw) begin
                    maxw = w;
                end
                total += w;
                if (w > WeightLimit) begin
                    heavy++;
                    excess += (w - WeightLimit) * (w - WeightLimit);
                end
            end
        end
        sc.applied      = go;
        sc.excess       = excess[15:0];
        sc.heavy_rows   = heavy[6:0];
        sc.max_weight   = maxw[5:0];
        sc.total_weight = total[11:0];
        sc.init_pairs   = pairs[5:0];
        return sc;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input logic func, input logic [4:0] dst, input logic [4:0] src,
                             output logic applied);
        t_score sc;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, src, dst};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sc = shear_and_score(func, dst, src);
        pending_scores = {pending_scores, sc};
        applied = sc.applied;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int n;
        n = ready_hold;
        if (n != 0) begin
            n--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
        end
        ready_hold = n;
        m_axis_tready <= (n == 0);
    end

    always @(posedge i_clk) begin
        t_score exp_sc;
        t_score act_sc;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_sc.applied      = m_axis_tuser;
            act_sc.excess       = m_axis_tdata[15:0];
            act_sc.heavy_rows   = m_axis_tdata[22:16];
            act_sc.max_weight   = m_axis_tdata[28:23];
            act_sc.total_weight = m_axis_tdata[40:29];
            act_sc.init_pairs   = m_axis_tdata[46:41];
            if (pending_scores.size() == 0) begin
                error_count++;
                if (error_count <= ReportLimit) begin
                    $display("Unexpected result word: %p", act_sc);
                end
            end else begin
                exp_sc = pending_scores.pop_front();
                if (act_sc.applied !== exp_sc.applied
                        || act_sc.excess !== exp_sc.excess
                        || act_sc.heavy_rows !== exp_sc.heavy_rows
                        || act_sc.max_weight !== exp_sc.max_weight
                        || act_sc.total_weight !== exp_sc.total_weight
                        || act_sc.init_pairs !== exp_sc.init_pairs) begin
                    error_count++;
                    if (error_count <= ReportLimit) begin
                        $display("Mismatch: expected %p", exp_sc);
                        $display("          actual   %p", act_sc);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end else begin
            if (stall_cycles >= WatchdogLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Equal indices are always refused by the guard and report the reset matrices.
    task automatic test_refused_equal();
        logic ok;
        send_word(FUNC_GUARDED, 5'd0, 5'd0, ok);
        send_word(FUNC_GUARDED, 5'd31, 5'd31, ok);
    endtask

    task automatic test_guarded_shears();
        logic ok;
        send_word(FUNC_GUARDED, 5'd0, 5'd31, ok);
        send_word(FUNC_GUARDED, 5'd31, 5'd0, ok);
        send_word(FUNC_GUARDED, 5'd0, 5'd31, ok);
        send_word(FUNC_GUARDED, 5'd16, 5'd15, ok);
    endtask

    // Two disjoint weight-two rows combine to weight four, which the guard refuses.
    task automatic test_weight_refusal();
        logic ok;
        send_word(FUNC_GUARDED, 5'd1, 5'd2, ok);
        send_word(FUNC_GUARDED, 5'd3, 5'd4, ok);
        send_word(FUNC_GUARDED, 5'd1, 5'd3, ok);
        send_word(FUNC_GUARDED, 5'd2, 5'd1, ok);
    endtask

    task automatic test_unguarded_undo();
        logic ok;
        send_word(FUNC_UNGUARDED, 5'd11, 5'd12, ok);
        send_word(FUNC_UNGUARDED, 5'd11, 5'd12, ok);
        send_word(FUNC_UNGUARDED, 5'd31, 5'd0, ok);
        send_word(FUNC_UNGUARDED, 5'd1, 5'd3, ok);
        send_word(FUNC_UNGUARDED, 5'd1, 5'd3, ok);
        send_word(FUNC_UNGUARDED, 5'd31, 5'd0, ok);
    endtask

    // Unguarded equal indices clear rows; two cleared rows then give a zero
    // candidate row, which the guard refuses.
    task automatic test_cleared_rows();
        logic ok;
        send_word(FUNC_UNGUARDED, 5'd20, 5'd20, ok);
        send_word(FUNC_UNGUARDED, 5'd21, 5'd21, ok);
        send_word(FUNC_GUARDED, 5'd20, 5'd21, ok);
        send_word(FUNC_UNGUARDED, 5'd20, 5'd21, ok);
        send_word(FUNC_UNGUARDED, 5'd20, 5'd20, ok);
    endtask

    task automatic test_random_shears(input int count, input bit with_idle);
        logic       ok;
        logic       func;
        logic [4:0] dst;
        logic [4:0] src;
        logic [9:0] pair;
        int         pick;
        int         w;
        idle_on = with_idle;
        for (int i = 0; i < count; i++) begin
            if (with_idle && i % 50 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            func = FUNC_GUARDED;
            dst  = 5'($urandom_range(0, 31));
            src  = 5'($urandom_range(0, 31));
            if (pick < 20) begin
                for (int t = 0; t < 32; t++) begin
                    dst = 5'($urandom_range(0, 31));
                    src = 5'($urandom_range(0, 31));
                    w   = $countones(basis_mat[dst] ^ basis_mat[src]);
                    if (dst != src && w >= 1 && w <= 2) begin
                        break;
                    end
                end
            end else if (pick < 45 && undo_pairs.size() != 0) begin
                pair = undo_pairs.pop_back();
                func = FUNC_UNGUARDED;
                dst  = pair[4:0];
                src  = pair[9:5];
            end else if (pick < 55) begin
                func = FUNC_UNGUARDED;
            end else if (pick < 57) begin
                func = FUNC_UNGUARDED;
                src  = dst;
            end
            send_word(func, dst, src, ok);
            if (dst == src && ok) begin
                undo_pairs.delete();
            end else if (ok && !(pick >= 20 && pick < 45 && func == FUNC_UNGUARDED)) begin
                undo_pairs = {undo_pairs, {src, dst}};
            end
        end
    endtask

    task automatic test_pause_until_drained();
        logic ok;
        wait_until_drained();
        send_word(FUNC_UNGUARDED, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), ok);
    endtask

    initial begin
        load_reset_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_refused_equal();
        test_guarded_shears();
        test_weight_refusal();
        test_unguarded_undo();
        test_cleared_rows();
        test_random_shears(350, 1'b1);
        test_pause_until_drained();
        test_random_shears(350, 1'b1);
        test_random_shears(100, 1'b0);
        wait_until_drained();
        repeat (SettleCycles) @(posedge i_clk);
        error_count += pending_scores.size();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/gsws_pkg.sv
hdl/gsws_popcnt.sv
hdl/gf2_shear_weight_scorer.sv
tb/testbench.sv
